/* hw/rtl/sitoa_pkg.sv */
// shared types, constants and helpers of the integer to text converter
`timescale 1ns / 1ps
`default_nettype none

package sitoa_pkg;

   // width of the signed input value
   localparam int VALUE_BITS = 32;

   // digit store holds one digit per value bit (base two worst case)
   localparam int STORE_DEPTH = VALUE_BITS;
   localparam int IDX_BITS    = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS  = $clog2(STORE_DEPTH + 1);

   // radix register and digit widths
   localparam int RADIX_BITS = 5;
   localparam int DIGIT_BITS = 4;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;

   // divider retires this many dividend bits per cycle
   localparam int CHUNK_BITS     = 8;
   localparam int CHUNKS         = VALUE_BITS / CHUNK_BITS;
   localparam int CHUNK_CNT_BITS = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   // ascii codes
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   // one classified item on its way from front to back
   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
      logic [RADIX_BITS-1:0] radix;
   } job_type;

   // one character on its way out
   typedef struct packed {
      logic [7:0] text_char;
      logic       is_last;
   } out_type;

   // digit value to lower-case ascii
   function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [7:0] wide;
      wide = {4'b0000, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + wide;
      end else begin
         return CHAR_LOWER_A - 8'd10 + wide;
      end
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/signed_integer_to_ascii_base.sv */
// top level of the signed integer to ascii text converter
`timescale 1ns / 1ps
`default_nettype none

// Converts each signed 32-bit value pushed on req_ into its text in the
// radix written through csr_wr_data (2 to 16, out-of-range values saturate;
// reset radix is ten), one ascii character per item on rsp_, most significant
// first, with a leading '-' for negative values, lower-case a to f, and
// rsp_is_last set on the final character. A two entry queue holds items
// classified by the front end while the back end works. The back end
// handles one value at a time: each digit takes one pass through the
// iterative divider (a load, then eight dividend bits per cycle), then each
// character leaves at up to one per cycle through the digit store read
// port and a two entry output queue.
module signed_integer_to_ascii_base (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_push,
   input  wire logic signed [sitoa_pkg::VALUE_BITS-1:0] req_value,
   output logic                                         req_full,
   output logic                                         rsp_empty,
   input  wire logic                                    rsp_pop,
   output logic             [7:0]                       rsp_text_char,
   output logic                                         rsp_is_last,
   input  wire logic                                    csr_wr_en,
   input  wire logic        [sitoa_pkg::RADIX_BITS-1:0] csr_wr_data
);

   logic               job_valid;
   logic               job_pop;
   sitoa_pkg::job_type job;

   // item intake and classification
   sitoa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_value   (req_value),
      .req_full    (req_full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .job_valid   (job_valid),
      .job         (job),
      .job_pop     (job_pop)
   );

   // conversion and character output
   sitoa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_text_char (rsp_text_char),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

`default_nettype wire

/* hw/rtl/sitoa_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sitoa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/sitoa_front.sv */
// front end: radix register, sign split and a two entry job queue
`timescale 1ns / 1ps
`default_nettype none

module sitoa_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   input  wire logic signed [sitoa_pkg::VALUE_BITS-1:0] req_value,
   output logic                                        req_full,
   input  wire logic                                   csr_wr_en,
   input  wire logic        [sitoa_pkg::RADIX_BITS-1:0] csr_wr_data,
   output logic                                        job_valid,
   output sitoa_pkg::job_type                          job,
   input  wire logic                                   job_pop
);

   logic [sitoa_pkg::RADIX_BITS-1:0] digit_base_ff;
   sitoa_pkg::job_type               entry_ff [2];
   logic                             wr_ptr_ff, wr_ptr_in;
   logic                             rd_ptr_ff, rd_ptr_in;
   logic [1:0]                       count_ff, count_in;
   logic                             push;
   sitoa_pkg::job_type               new_job;
   logic [sitoa_pkg::VALUE_BITS-1:0] raw;

   // classify: sign, unsigned magnitude, saturated radix
   always_comb begin
      raw         = req_value;
      new_job.neg = raw[sitoa_pkg::VALUE_BITS-1];
      new_job.mag = new_job.neg ? (~raw + 1'b1) : raw;
      if (digit_base_ff < sitoa_pkg::RADIX_MIN) begin
         new_job.radix = sitoa_pkg::RADIX_MIN;
      end else if (digit_base_ff > sitoa_pkg::RADIX_MAX) begin
         new_job.radix = sitoa_pkg::RADIX_MAX;
      end else begin
         new_job.radix = digit_base_ff;
      end
   end

   // queue control
   assign req_full  = (count_ff == 2'd2);
   assign push      = req_push && !req_full;
   assign job_valid = (count_ff != 2'd0);
   assign job       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ job_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_base_ff <= sitoa_pkg::RADIX_RESET;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         count_ff      <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            digit_base_ff <= csr_wr_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sitoa_divider.sv */
// iterative divider by a small radix, several dividend bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module sitoa_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [sitoa_pkg::VALUE_BITS-1:0]    dividend,
   input  wire logic [sitoa_pkg::RADIX_BITS-1:0]    radix,
   output logic                                     done,
   output logic      [sitoa_pkg::VALUE_BITS-1:0]    quotient,
   output logic      [sitoa_pkg::DIGIT_BITS-1:0]    remainder
);

   logic [sitoa_pkg::VALUE_BITS-1:0]     work_ff, work_in;
   logic [sitoa_pkg::DIGIT_BITS-1:0]     rem_ff, rem_in;
   logic [sitoa_pkg::RADIX_BITS-1:0]     radix_ff;
   logic [sitoa_pkg::CHUNK_CNT_BITS-1:0] cnt_ff;
   logic                                 busy_ff;
   logic                                 done_ff;
   logic                                 final_chunk;
   logic [sitoa_pkg::CHUNK_BITS-1:0]     q_bits;
   logic [sitoa_pkg::RADIX_BITS-1:0]     trial;
   logic [sitoa_pkg::DIGIT_BITS-1:0]     r;

   // restoring division over the top chunk of the working word
   always_comb begin
      r      = rem_ff;
      q_bits = '0;
      trial  = '0;
      for (int i = 0; i < sitoa_pkg::CHUNK_BITS; i++) begin
         trial = {r, work_ff[sitoa_pkg::VALUE_BITS-1-i]};
         if (trial >= radix_ff) begin
            r = sitoa_pkg::DIGIT_BITS'(trial - radix_ff);
            q_bits[sitoa_pkg::CHUNK_BITS-1-i] = 1'b1;
         end else begin
            r = trial[sitoa_pkg::DIGIT_BITS-1:0];
         end
      end
      rem_in  = r;
      work_in = (work_ff << sitoa_pkg::CHUNK_BITS)
              | sitoa_pkg::VALUE_BITS'(q_bits);
   end

   assign final_chunk =
      (cnt_ff == sitoa_pkg::CHUNK_CNT_BITS'(sitoa_pkg::CHUNKS - 1));

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && final_chunk;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (final_chunk) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff  <= dividend;
         rem_ff   <= '0;
         radix_ff <= radix;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* hw/rtl/sitoa_back.sv */
// back end: digit extraction into the digit store, then text output
`timescale 1ns / 1ps
`default_nettype none

module sitoa_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_valid,
   input  wire sitoa_pkg::job_type job,
   output logic                    job_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [7:0]              rsp_text_char,
   output logic                    rsp_is_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic                             neg_ff, neg_in;
   logic [sitoa_pkg::RADIX_BITS-1:0] radix_ff, radix_in;
   logic [sitoa_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [sitoa_pkg::IDX_BITS-1:0]   idx_ff, idx_in;

   logic                             div_start;
   logic [sitoa_pkg::VALUE_BITS-1:0] div_dividend;
   logic [sitoa_pkg::RADIX_BITS-1:0] div_radix;
   logic                             div_done;
   logic [sitoa_pkg::VALUE_BITS-1:0] div_quotient;
   logic [sitoa_pkg::DIGIT_BITS-1:0] div_remainder;
   logic                             digits_done;

   logic [sitoa_pkg::DIGIT_BITS-1:0] ram_rdata;

   logic                             issue;
   logic                             rd_valid_ff, rd_valid_in;
   logic                             rd_minus_ff, rd_minus_in;
   logic                             rd_last_ff, rd_last_in;

   sitoa_pkg::out_type               out_ff [2];
   sitoa_pkg::out_type               out_item;
   logic [1:0]                       occ_ff, occ_in;
   logic                             owr_ptr_ff, ord_ptr_ff;
   logic                             pop_fire;
   logic [2:0]                       occ_ahead;

   // division unit
   sitoa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_radix),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // digit store, least significant digit at address zero
   sitoa_ram #(
      .WIDTH (sitoa_pkg::DIGIT_BITS),
      .DEPTH (sitoa_pkg::STORE_DEPTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (state_ff == ST_DIV && div_done),
      .wr_addr (count_ff[sitoa_pkg::IDX_BITS-1:0]),
      .wr_data (div_remainder),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // output queue room, counting the read still in flight
   assign pop_fire  = rsp_pop && !rsp_empty;
   assign occ_ahead = {1'b0, occ_ff} + {2'b00, rd_valid_ff} - {2'b00, pop_fire};
   assign issue     = (state_ff == ST_EMIT) && (occ_ahead < 3'd2);

   // digit loop ends on a zero quotient or a full store
   assign digits_done = (div_quotient == '0)
      || (count_ff == sitoa_pkg::COUNT_BITS'(sitoa_pkg::STORE_DEPTH - 1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      radix_in     = radix_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      job_pop      = 1'b0;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      div_radix    = radix_ff;
      rd_valid_in  = issue;
      rd_minus_in  = neg_ff;
      rd_last_in   = !neg_ff && (idx_ff == '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop      = 1'b1;
               div_start    = 1'b1;
               div_dividend = job.mag;
               div_radix    = job.radix;
               neg_in       = job.neg;
               radix_in     = job.radix;
               count_in     = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               count_in = count_ff + 1'b1;
               if (digits_done) begin
                  idx_in   = count_ff[sitoa_pkg::IDX_BITS-1:0];
                  state_in = ST_EMIT;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               if (neg_ff) begin
                  neg_in = 1'b0;
               end else if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         neg_ff      <= 1'b0;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         neg_ff      <= neg_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
      radix_ff    <= radix_in;
      idx_ff      <= idx_in;
      rd_minus_ff <= rd_minus_in;
      rd_last_ff  <= rd_last_in;
   end

   // character formed as the store data returns
   always_comb begin
      out_item.text_char = rd_minus_ff ? sitoa_pkg::CHAR_MINUS
                                       : sitoa_pkg::digit_char(ram_rdata);
      out_item.is_last   = rd_last_ff;
   end

   // two entry output queue
   always_comb begin
      occ_in = occ_ff + {1'b0, rd_valid_ff} - {1'b0, pop_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= 2'd0;
         owr_ptr_ff <= 1'b0;
         ord_ptr_ff <= 1'b0;
      end else begin
         occ_ff     <= occ_in;
         owr_ptr_ff <= owr_ptr_ff ^ rd_valid_ff;
         ord_ptr_ff <= ord_ptr_ff ^ pop_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         out_ff[owr_ptr_ff] <= out_item;
      end
   end

   assign rsp_empty     = (occ_ff == 2'd0);
   assign rsp_text_char = out_ff[ord_ptr_ff].text_char;
   assign rsp_is_last   = out_ff[ord_ptr_ff].is_last;

endmodule

`default_nettype wire

/* sim/tb_signed_integer_to_ascii_base.sv */
// self-checking testbench of the signed integer to ascii text converter
`timescale 1ns / 1ps

module tb_signed_integer_to_ascii_base;

   localparam int RESET_CYCLES  = 12;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 60;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 15;
   localparam int REPORT_LIMIT  = 10;

   localparam logic signed [sitoa_pkg::VALUE_BITS-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [sitoa_pkg::VALUE_BITS-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

   // one directed conversion: radix, value and, where obvious, its text
   typedef struct {
      logic [sitoa_pkg::RADIX_BITS-1:0]        radix;
      logic signed [sitoa_pkg::VALUE_BITS-1:0] value;
      string                                   text;
   } text_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic signed [sitoa_pkg::VALUE_BITS-1:0] req_value = '0;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [7:0] rsp_text_char;
   logic rsp_is_last;
   logic csr_wr_en = 1'b0;
   logic [sitoa_pkg::RADIX_BITS-1:0] csr_wr_data = '0;

   // expected characters, oldest first, and the radix the block holds
   sitoa_pkg::out_type text_expected[$];
   logic [sitoa_pkg::RADIX_BITS-1:0] radix_setting = sitoa_pkg::RADIX_RESET;
   string digit_glyphs = "0123456789abcdef";

   bit steady_flow = 1'b0;
   int unsigned pop_hold = 0;
   int unsigned idle_cycles = 0;
   int unsigned fail_count = 0;
   int unsigned numbers_sent = 0;
   int unsigned chars_checked = 0;
   int unsigned radix_writes = 0;

   // directed cases: extremes, zero, every digit letter, radix saturation
   text_case_type directed_cases [23] = '{
      '{5'd10, 32'sd0,         "0"},
      '{5'd10, MOST_POSITIVE,  "2147483647"},
      '{5'd10, MOST_NEGATIVE,  "-2147483648"},
      '{5'd10, -32'sd1,        "-1"},
      '{5'd10, 32'sd10,        ""},
      '{5'd10, -32'sd90817,    ""},
      '{5'd16, MOST_POSITIVE,  "7fffffff"},
      '{5'd16, MOST_NEGATIVE,  "-80000000"},
      '{5'd16, 32'sh00ab_cdef, "abcdef"},
      '{5'd16, -32'sd1,        "-1"},
      '{5'd2,  32'sd5,         "101"},
      '{5'd2,  -32'sd2,        "-10"},
      '{5'd2,  MOST_NEGATIVE,  ""},
      '{5'd2,  MOST_POSITIVE,  ""},
      '{5'd0,  32'sd6,         "110"},
      '{5'd1,  -32'sd3,        "-11"},
      '{5'd17, 32'sd255,       "ff"},
      '{5'd31, -32'sd255,      "-ff"},
      '{5'd31, MOST_NEGATIVE,  "-80000000"},
      '{5'd8,  MOST_NEGATIVE,  ""},
      '{5'd3,  32'sh1234_5678, ""},
      '{5'd7,  -32'sd1000,     ""},
      '{5'd10, 32'sd12345,     ""}
   };

   signed_integer_to_ascii_base u_top (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_value     (req_value),
      .req_full      (req_full),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_text_char (rsp_text_char),
      .rsp_is_last   (rsp_is_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // spell a value in the given radix, sign first, most significant digit first
   function automatic void spell_number(
      input logic signed [sitoa_pkg::VALUE_BITS-1:0] value,
      input logic [sitoa_pkg::RADIX_BITS-1:0] radix);
      logic [sitoa_pkg::VALUE_BITS-1:0] magnitude;
      logic [sitoa_pkg::RADIX_BITS-1:0] base;
      logic [sitoa_pkg::DIGIT_BITS-1:0] digits[$];
      sitoa_pkg::out_type glyph;
      base = radix;
      if (radix < 5'd2) begin
         base = 5'd2;
      end else if (radix > 5'd16) begin
         base = 5'd16;
      end
      magnitude = value[sitoa_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;
      if (value[sitoa_pkg::VALUE_BITS-1]) begin
         glyph.text_char = 8'h2d;
         glyph.is_last = 1'b0;
         text_expected.push_back(glyph);
      end
      do begin
         digits.push_front(sitoa_pkg::DIGIT_BITS'(magnitude % base));
         magnitude = magnitude / base;
      end while (magnitude != 0);
      foreach (digits[i]) begin
         glyph.text_char = digit_glyphs[digits[i]];
         glyph.is_last = (i == digits.size() - 1);
         text_expected.push_back(glyph);
      end
   endfunction

   // queue a text typed in by hand
   function automatic void expect_text(input string text);
      sitoa_pkg::out_type glyph;
      for (int i = 0; i < text.len(); i++) begin
         glyph.text_char = text[i];
         glyph.is_last = (i == text.len() - 1);
         text_expected.push_back(glyph);
      end
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // random value: full range, short magnitudes or the extremes
   function automatic logic signed [sitoa_pkg::VALUE_BITS-1:0] pick_number();
      logic signed [sitoa_pkg::VALUE_BITS-1:0] value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = $urandom;
         4, 5: value = $urandom_range(0, 40);
         6, 7: value = $urandom >> $urandom_range(0, 31);
         8: value = $urandom_range(0, 1) ? MOST_NEGATIVE : MOST_POSITIVE;
         default: value = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      endcase
      if (value != MOST_NEGATIVE && $urandom_range(0, 1)) begin
         value = -value;
      end
      return value;
   endfunction

   // offer one item, predict its text once taken, then maybe pause
   task automatic send_number(input logic signed [sitoa_pkg::VALUE_BITS-1:0] value,
                              input string text);
      int unsigned gap;
      req_push <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_full);
      if (text.len() > 0) begin
         expect_text(text);
      end else begin
         spell_number(value, radix_setting);
      end
      numbers_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering items and wait until every expected character is out
   task automatic settle_idle();
      req_push <= 1'b0;
      while (text_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // radix register write, only while the block is idle
   task automatic write_radix(input logic [sitoa_pkg::RADIX_BITS-1:0] radix);
      csr_wr_en <= 1'b1;
      csr_wr_data <= radix;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      radix_setting = radix;
      radix_writes++;
   endtask

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // result side: pop with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop <= 1'b1;
         pop_hold <= pick_gap();
      end
   end

   // compare each taken character with the oldest expected one
   always @(posedge clock) begin
      sitoa_pkg::out_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         chars_checked++;
         if (text_expected.size() == 0) begin
            note_failure($sformatf("unexpected char %h last %b", rsp_text_char, rsp_is_last));
         end else begin
            want = text_expected.pop_front();
            if (rsp_text_char !== want.text_char) begin
               note_failure($sformatf("text_char expected %h got %h",
                                      want.text_char, rsp_text_char));
            end
            if (rsp_is_last !== want.is_last) begin
               note_failure($sformatf("is_last expected %b got %b (char %h)",
                                      want.is_last, rsp_is_last, want.text_char));
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] timeout: no progress for %0d cycles", $realtime, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // stimulus: directed table, then random phases each with its own radix
   initial begin
      logic [sitoa_pkg::RADIX_BITS-1:0] radix;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cases[i]) begin
         if (directed_cases[i].radix != radix_setting) begin
            settle_idle();
            write_radix(directed_cases[i].radix);
         end
         send_number(directed_cases[i].value, directed_cases[i].text);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            7: radix = sitoa_pkg::RADIX_BITS'($urandom_range(0, 1));
            8: radix = sitoa_pkg::RADIX_BITS'($urandom_range(17, 31));
            default: radix = sitoa_pkg::RADIX_BITS'($urandom_range(2, 16));
         endcase
         settle_idle();
         write_radix(radix);
         steady_flow = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ITEMS) send_number(pick_number(), "");
      end
      steady_flow = 1'b0;

      settle_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (text_expected.size() != 0) begin
         fail_count += text_expected.size();
         $display("%0d expected characters never arrived", text_expected.size());
      end
      $display("converted %0d numbers under %0d radix writes, %0d characters compared",
               numbers_sent, radix_writes, chars_checked);
      $display("covered zero, both extremes, saturated radix values and random stalls");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/sitoa_pkg.sv
hw/rtl/sitoa_ram.sv
hw/rtl/sitoa_front.sv
hw/rtl/sitoa_divider.sv
hw/rtl/sitoa_back.sv
hw/rtl/signed_integer_to_ascii_base.sv
sim/tb_signed_integer_to_ascii_base.sv
